// ===== src/vfh_pkg.sv =====
// Shared types, codes and constants of the VP8 frame header parser.
// No dependencies; used by vfh_ctrl, vfh_dp and vp8_frame_header_parser.
package vfh_pkg;

  localparam int MAX_PARTITIONS_DEF = 8;
  localparam int HEADER_BYTES       = 10;
  localparam int TAG_BYTES          = 3;
  localparam int START_END          = 6;
  localparam int POS_W              = 24;
  localparam int FPL_W              = 19;
  localparam int CFG_W              = 14;
  localparam int CFG_IDX_W          = 2;
  localparam logic [POS_W-1:0] POS_MAX = '1;
  localparam logic [7:0] START_B0 = 8'h9d;
  localparam logic [7:0] START_B1 = 8'h01;
  localparam logic [7:0] START_B2 = 8'h2a;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_WIDTH,
    REG_HEIGHT,
    REG_PARTIAL,
    REG_PCOUNT
  } cfg_reg_t;

  typedef enum logic [2:0] {
    STS_OK,
    STS_BAD_VERSION,
    STS_BAD_LENGTH,
    STS_NO_START,
    STS_SIZE_SCALE,
    STS_TRUNCATED,
    STS_OVERRUN
  } status_t;

  typedef enum logic [1:0] {
    CORR_NONE,
    CORR_FIRST,
    CORR_FRAME
  } corr_t;

  typedef enum logic {
    KIND_HEADER,
    KIND_PART
  } kind_t;

  typedef enum logic [2:0] {
    S_RX,
    S_EVAL,
    S_PREP,
    S_WALK,
    S_HDR,
    S_DESC
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic take_byte;
    logic eval;
    logic prep;
    logic walk;
    logic reload;
    logic load_hdr;
    logic load_desc;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic walk_done;
    logic hdr_only;
    logic desc_last;
    logic slot_free;
  } sts_t;

  // Divide a table byte offset (below 24) by three.
  function automatic logic [2:0] div3(input logic [4:0] q);
    logic [8:0] prod;
    prod = 9'(q) * 9'd11;
    return prod[7:5];
  endfunction

endpackage

// ===== src/vfh_ctrl.sv =====
// Controller state machine of the VP8 frame header parser.
// Depends on vfh_pkg; drives the command word of vfh_dp.
module vfh_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  input  logic            in_end_of_frame,
  output logic            in_ready,
  input  vfh_pkg::sts_t   sts,
  output vfh_pkg::cmd_t   cmd
);

  vfh_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= vfh_pkg::S_RX;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      vfh_pkg::S_RX: begin
        if (in_valid && in_end_of_frame) state_nxt = vfh_pkg::S_EVAL;
      end
      vfh_pkg::S_EVAL: state_nxt = vfh_pkg::S_PREP;
      vfh_pkg::S_PREP: state_nxt = vfh_pkg::S_WALK;
      vfh_pkg::S_WALK: begin
        if (sts.walk_done) state_nxt = vfh_pkg::S_HDR;
      end
      vfh_pkg::S_HDR: begin
        if (sts.slot_free) state_nxt = sts.hdr_only ? vfh_pkg::S_RX : vfh_pkg::S_DESC;
      end
      vfh_pkg::S_DESC: begin
        if (sts.slot_free && sts.desc_last) state_nxt = vfh_pkg::S_RX;
      end
      default: state_nxt = vfh_pkg::S_RX;
    endcase
  end

  // Outputs.
  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    case (state_r)
      vfh_pkg::S_RX: begin
        in_ready      = 1'b1;
        cmd.take_byte = in_valid;
      end
      vfh_pkg::S_EVAL: cmd.eval = 1'b1;
      vfh_pkg::S_PREP: cmd.prep = 1'b1;
      vfh_pkg::S_WALK: begin
        cmd.walk   = !sts.walk_done;
        cmd.reload = sts.walk_done;
      end
      vfh_pkg::S_HDR:  cmd.load_hdr  = sts.slot_free;
      vfh_pkg::S_DESC: cmd.load_desc = sts.slot_free;
      default: ;
    endcase
  end

endmodule

// ===== src/vfh_dp.sv =====
// Datapath of the VP8 frame header parser: config registers, header bytes,
// partition length table, header checks, partition walk and output register.
// Depends on vfh_pkg; steered by vfh_ctrl.
module vfh_dp #(
  parameter int MAX_PARTITIONS = vfh_pkg::MAX_PARTITIONS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [vfh_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [vfh_pkg::CFG_W-1:0]     cfg_wdata,
  input  logic [7:0]                    in_data_byte,
  input  logic                          in_end_of_frame,
  input  logic                          out_ready,
  input  vfh_pkg::cmd_t                 cmd,
  output vfh_pkg::sts_t                 sts,
  output logic                          out_valid,
  output logic                          out_item_kind,
  output logic                          out_is_key_frame,
  output logic                          out_show_flag,
  output logic                          out_experimental_flag,
  output logic                          out_loop_filter_off,
  output logic [2:0]                    out_status,
  output logic [1:0]                    out_corruption,
  output logic [3:0]                    out_part_index,
  output logic [vfh_pkg::POS_W-1:0]     out_part_offset,
  output logic [vfh_pkg::POS_W-1:0]     out_part_length,
  output logic                          out_last_result
);

  localparam int PW        = vfh_pkg::POS_W;
  localparam int IDX_W     = (MAX_PARTITIONS > 1) ? $clog2(MAX_PARTITIONS) : 1;
  localparam int TBL_DEPTH = (MAX_PARTITIONS > 1) ? MAX_PARTITIONS - 1 : 1;
  localparam int TBL_BYTES = 3 * (MAX_PARTITIONS - 1);
  localparam int R_W       = vfh_pkg::FPL_W + 1;

  // Configuration.
  logic [vfh_pkg::CFG_W-1:0] exp_w_r, exp_h_r;
  logic                      partial_r;
  logic [3:0]                pcount_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      exp_w_r   <= '0;
      exp_h_r   <= '0;
      partial_r <= 1'b0;
      pcount_r  <= 4'd1;
    end else if (cfg_we) begin
      case (vfh_pkg::cfg_reg_t'(cfg_index))
        vfh_pkg::REG_WIDTH:   exp_w_r   <= cfg_wdata;
        vfh_pkg::REG_HEIGHT:  exp_h_r   <= cfg_wdata;
        vfh_pkg::REG_PARTIAL: partial_r <= cfg_wdata[0];
        vfh_pkg::REG_PCOUNT:  pcount_r  <= cfg_wdata[3:0];
        default: ;
      endcase
    end
  end

  // Byte capture.
  logic [PW-1:0] byte_pos_r;
  logic [7:0]    hb_r [vfh_pkg::HEADER_BYTES];
  logic [PW-1:0] tbl_r [TBL_DEPTH];
  logic [PW-1:0] size_r;

  logic [3:0]     cap_off;
  logic [R_W-1:0] cap_t;
  logic [PW-1:0]  cap_dq;
  logic           cap_hit;
  logic [4:0]     cap_q;
  logic [2:0]     cap_ent;
  logic [4:0]     cap_lane5;
  logic [1:0]     cap_lane;

  always_comb begin
    cap_off   = hb_r[0][0] ? 4'(vfh_pkg::TAG_BYTES) : 4'(vfh_pkg::HEADER_BYTES);
    cap_t     = R_W'(cap_off) + R_W'({hb_r[2], hb_r[1], hb_r[0][7:5]});
    cap_dq    = byte_pos_r - PW'(cap_t);
    cap_hit   = (byte_pos_r >= PW'(vfh_pkg::TAG_BYTES)) && (byte_pos_r >= PW'(cap_t)) &&
                (cap_dq < PW'(TBL_BYTES));
    cap_q     = cap_dq[4:0];
    cap_ent   = vfh_pkg::div3(cap_q);
    cap_lane5 = cap_q - {cap_ent, 1'b0} - 5'(cap_ent);
    cap_lane  = cap_lane5[1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_pos_r <= '0;
    end else if (cmd.take_byte) begin
      if (in_end_of_frame) begin
        byte_pos_r <= '0;
      end else if (byte_pos_r != vfh_pkg::POS_MAX) begin
        byte_pos_r <= byte_pos_r + PW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take_byte) begin
      if (byte_pos_r < PW'(vfh_pkg::HEADER_BYTES)) begin
        hb_r[byte_pos_r[3:0]] <= in_data_byte;
      end
      if (cap_hit) begin
        tbl_r[cap_ent[IDX_W-1:0]][8*cap_lane +: 8] <= in_data_byte;
      end
      if (in_end_of_frame) begin
        size_r <= (byte_pos_r != vfh_pkg::POS_MAX) ? byte_pos_r + PW'(1) : byte_pos_r;
      end
    end
  end

  // Header evaluation.
  logic              ev_key, ev_show, ev_exper, ev_lf, ev_trunc;
  logic [2:0]        ev_ver;
  logic [3:0]        ev_off;
  logic [vfh_pkg::FPL_W-1:0] ev_len;
  logic [R_W-1:0]    ev_r;
  logic [13:0]       ev_w, ev_h;
  vfh_pkg::status_t  ev_status;
  vfh_pkg::corr_t    ev_corr;
  logic [3:0]        ev_fpo;
  logic [PW-1:0]     ev_fpl;
  logic [IDX_W-1:0]  ev_last;

  always_comb begin
    ev_key    = ~hb_r[0][0];
    ev_show   = hb_r[0][4];
    ev_ver    = hb_r[0][3:1];
    ev_off    = hb_r[0][0] ? 4'(vfh_pkg::TAG_BYTES) : 4'(vfh_pkg::HEADER_BYTES);
    ev_len    = {hb_r[2], hb_r[1], hb_r[0][7:5]};
    ev_r      = R_W'(ev_off) + R_W'(ev_len);
    ev_w      = {hb_r[7][5:0], hb_r[6]};
    ev_h      = {hb_r[9][5:0], hb_r[8]};
    ev_exper  = 1'b0;
    ev_lf     = 1'b0;
    ev_trunc  = 1'b0;
    ev_status = vfh_pkg::STS_OK;
    ev_corr   = vfh_pkg::CORR_NONE;
    ev_fpo    = '0;
    ev_fpl    = '0;
    if (!(ev_ver inside {3'd0, 3'd4, 3'd6})) begin
      ev_status = vfh_pkg::STS_BAD_VERSION;
    end else begin
      ev_exper = (ev_ver != 3'd0);
      ev_lf    = (ev_ver == 3'd6);
      if (size_r < PW'(vfh_pkg::TAG_BYTES)) begin
        ev_trunc = 1'b1;
      end else begin
        if (size_r <= PW'(ev_r)) begin
          if (!partial_r) begin
            ev_status = vfh_pkg::STS_BAD_LENGTH;
          end else if (size_r < PW'(ev_off)) begin
            ev_trunc = 1'b1;
          end else begin
            ev_corr = vfh_pkg::CORR_FIRST;
            ev_fpo  = ev_off;
            ev_fpl  = size_r - PW'(ev_off);
          end
        end else begin
          ev_fpo = ev_off;
          ev_fpl = PW'(ev_len);
        end
        if (ev_status == vfh_pkg::STS_OK && !ev_trunc && ev_key) begin
          if (size_r < PW'(vfh_pkg::START_END)) begin
            ev_trunc = 1'b1;
          end else if (hb_r[3] != vfh_pkg::START_B0 || hb_r[4] != vfh_pkg::START_B1 ||
                       hb_r[5] != vfh_pkg::START_B2) begin
            ev_status = vfh_pkg::STS_NO_START;
          end else if (size_r < PW'(vfh_pkg::HEADER_BYTES)) begin
            ev_trunc = 1'b1;
          end else if (ev_w != exp_w_r || ev_h != exp_h_r ||
                       hb_r[7][7:6] != 2'd0 || hb_r[9][7:6] != 2'd0) begin
            ev_status = vfh_pkg::STS_SIZE_SCALE;
          end
        end
      end
      if (ev_status == vfh_pkg::STS_OK && ev_trunc) begin
        if (!partial_r) begin
          ev_status = vfh_pkg::STS_TRUNCATED;
        end else begin
          ev_corr  = vfh_pkg::CORR_FRAME;
          ev_key   = 1'b0;
          ev_exper = 1'b0;
          ev_lf    = 1'b0;
          ev_fpo   = '0;
          ev_fpl   = '0;
        end
      end
    end
    // Header errors report no first partition.
    if (ev_status != vfh_pkg::STS_OK) begin
      ev_fpo = '0;
      ev_fpl = '0;
    end
    // Clamp the partition count to 1..MAX_PARTITIONS; hold n-1.
    if (pcount_r == 4'd0) begin
      ev_last = '0;
    end else if (pcount_r > 4'(MAX_PARTITIONS)) begin
      ev_last = IDX_W'(MAX_PARTITIONS - 1);
    end else begin
      ev_last = IDX_W'(pcount_r - 4'd1);
    end
  end

  logic             key_r, show_r, exper_r, lf_r;
  vfh_pkg::status_t status_r;
  vfh_pkg::corr_t   corr_r;
  logic [3:0]       fpo_r;
  logic [PW-1:0]    fpl_r;
  logic [R_W-1:0]   r_r;
  logic [IDX_W-1:0] last_r;

  // Partition walk.
  logic [PW-1:0]    pos_r, rem_r, base_pos_r, base_rem_r;
  logic [IDX_W-1:0] idx_r;
  logic [PW-1:0]    pr_avail, pr_need, pr_pos, pr_rem;
  logic             pr_fail;
  logic [PW-1:0]    wk_len;
  logic             wk_over;

  always_comb begin
    pr_avail = size_r - PW'(r_r);
    pr_need  = PW'(last_r) + PW'(last_r) + PW'(last_r);
    pr_fail  = 1'b0;
    pr_pos   = PW'(r_r) + pr_need;
    pr_rem   = pr_avail - pr_need;
    if (corr_r != vfh_pkg::CORR_NONE) begin
      pr_fail = (last_r != '0);
      pr_pos  = size_r;
      pr_rem  = '0;
    end else if (pr_avail < pr_need) begin
      pr_fail = 1'b1;
    end
    wk_len  = tbl_r[idx_r];
    wk_over = wk_len > rem_r;
  end

  always_ff @(posedge clk) begin
    if (cmd.eval) begin
      key_r    <= ev_key;
      show_r   <= ev_show;
      exper_r  <= ev_exper;
      lf_r     <= ev_lf;
      status_r <= ev_status;
      corr_r   <= ev_corr;
      fpo_r    <= ev_fpo;
      fpl_r    <= ev_fpl;
      r_r      <= ev_r;
      last_r   <= ev_last;
    end else if (cmd.prep) begin
      if (status_r == vfh_pkg::STS_OK && pr_fail) status_r <= vfh_pkg::STS_OVERRUN;
      base_pos_r <= pr_pos;
      base_rem_r <= pr_rem;
      pos_r      <= pr_pos;
      rem_r      <= pr_rem;
      idx_r      <= '0;
    end else if (cmd.walk) begin
      if (wk_over) begin
        status_r <= vfh_pkg::STS_OVERRUN;
      end else begin
        pos_r <= pos_r + wk_len;
        rem_r <= rem_r - wk_len;
        idx_r <= idx_r + IDX_W'(1);
      end
    end else if (cmd.reload) begin
      pos_r <= base_pos_r;
      rem_r <= base_rem_r;
      idx_r <= '0;
    end else if (cmd.load_desc) begin
      pos_r <= pos_r + wk_len;
      rem_r <= rem_r - wk_len;
      idx_r <= idx_r + IDX_W'(1);
    end
  end

  // Output register.
  logic out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_hdr || cmd.load_desc) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_hdr || cmd.load_desc) begin
      out_is_key_frame      <= key_r;
      out_show_flag         <= show_r;
      out_experimental_flag <= exper_r;
      out_loop_filter_off   <= lf_r;
      out_corruption        <= corr_r;
    end
    if (cmd.load_hdr) begin
      out_item_kind   <= vfh_pkg::KIND_HEADER;
      out_status      <= status_r;
      out_part_index  <= '0;
      out_part_offset <= PW'(fpo_r);
      out_part_length <= fpl_r;
      out_last_result <= (status_r != vfh_pkg::STS_OK);
    end else if (cmd.load_desc) begin
      out_item_kind   <= vfh_pkg::KIND_PART;
      out_status      <= vfh_pkg::STS_OK;
      out_part_index  <= 4'(idx_r) + 4'd1;
      out_part_offset <= pos_r;
      out_part_length <= (idx_r == last_r) ? rem_r : wk_len;
      out_last_result <= (idx_r == last_r);
    end
  end

  assign out_valid     = out_valid_r;
  assign sts.slot_free = !out_valid_r || out_ready;
  assign sts.hdr_only  = (status_r != vfh_pkg::STS_OK);
  assign sts.desc_last = (idx_r == last_r);
  assign sts.walk_done = (status_r != vfh_pkg::STS_OK) || (corr_r != vfh_pkg::CORR_NONE) ||
                         (idx_r == last_r);

endmodule

// ===== src/vp8_frame_header_parser.sv =====
// VP8 frame header parser, top level: ports, controller and datapath.
// Depends on vfh_pkg, vfh_ctrl and vfh_dp.
//
// Feed a compressed VP8 frame one byte per word on the in_ channel and mark
// its final byte with in_end_of_frame. Bytes before the final one are taken
// at one per cycle and produce no word. At the final byte the block decodes
// the 3-byte frame tag, checks a key frame's start code, size and scale
// against cfg registers 0..1, and then walks the DCT partition length table
// one entry per cycle. It sends a header word (part_index 0, the first
// partition) and, for a good frame, one descriptor word per DCT partition,
// the final word of a frame carrying out_last_result. At frame end the
// header is evaluated in the S_EVAL and S_PREP states, then the table walk
// covers up to n-1 entries for n partitions, then words go out one per
// cycle while out_ready is high. in_ready drops from the final byte until
// the last word has been loaded into the output register, so the next
// frame may start while that word still waits.
// Configuration (cfg_we, cfg_index, cfg_wdata): 0 expected width, 1 expected
// height, 2 accept partial frames, 3 partition count; write only when idle.
module vp8_frame_header_parser #(
  parameter int MAX_PARTITIONS = vfh_pkg::MAX_PARTITIONS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // configuration
  input  logic                          cfg_we,
  input  logic [vfh_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [vfh_pkg::CFG_W-1:0]     cfg_wdata,
  // byte stream
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [7:0]                    in_data_byte,
  input  logic                          in_end_of_frame,
  // results
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          out_item_kind,
  output logic                          out_is_key_frame,
  output logic                          out_show_flag,
  output logic                          out_experimental_flag,
  output logic                          out_loop_filter_off,
  output logic [2:0]                    out_status,
  output logic [1:0]                    out_corruption,
  output logic [3:0]                    out_part_index,
  output logic [vfh_pkg::POS_W-1:0]     out_part_offset,
  output logic [vfh_pkg::POS_W-1:0]     out_part_length,
  output logic                          out_last_result
);

  vfh_pkg::cmd_t cmd;
  vfh_pkg::sts_t sts;

  // Sequence capture, evaluation, table walk and emission.
  vfh_ctrl u_ctrl (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_end_of_frame (in_end_of_frame),
    .in_ready        (in_ready),
    .sts             (sts),
    .cmd             (cmd)
  );

  // Hold the config, header bytes and partition table; compute and drive words.
  vfh_dp #(
    .MAX_PARTITIONS (MAX_PARTITIONS)
  ) u_dp (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .cfg_we                (cfg_we),
    .cfg_index             (cfg_index),
    .cfg_wdata             (cfg_wdata),
    .in_data_byte          (in_data_byte),
    .in_end_of_frame       (in_end_of_frame),
    .out_ready             (out_ready),
    .cmd                   (cmd),
    .sts                   (sts),
    .out_valid             (out_valid),
    .out_item_kind         (out_item_kind),
    .out_is_key_frame      (out_is_key_frame),
    .out_show_flag         (out_show_flag),
    .out_experimental_flag (out_experimental_flag),
    .out_loop_filter_off   (out_loop_filter_off),
    .out_status            (out_status),
    .out_corruption        (out_corruption),
    .out_part_index        (out_part_index),
    .out_part_offset       (out_part_offset),
    .out_part_length       (out_part_length),
    .out_last_result       (out_last_result)
  );

endmodule

// ===== tb/tb_top.sv =====
// Self-checking testbench for vp8_frame_header_parser: byte stream in, header and
// partition descriptor words out, checked against a built-in frame decoder.
// Depends on vfh_pkg and vp8_frame_header_parser only.
module tb_top;
  import vfh_pkg::*;

  // Timing and run shape.
  localparam int RESET_CYCLES  = 11;
  localparam int STALL_LIMIT   = 3000;
  localparam int SETTLE_CYCLES = 16;
  localparam int HOLD_CYCLES   = 300;
  localparam int NUM_PHASES    = 6;
  localparam int PHASE_WORDS   = 72;
  localparam int MAX_REPORTS   = 10;
  localparam int NUM_DIRECTED  = 26;
  localparam int MAX_PARTS     = MAX_PARTITIONS_DEF;

  // Frame tag version codes.
  localparam logic [2:0] VER_BASE           = 3'd0;
  localparam logic [2:0] VER_EXPERIMENTAL   = 3'd4;
  localparam logic [2:0] VER_NO_LOOP_FILTER = 3'd6;

  // Receiver stall patterns.
  localparam int RX_FREE = 0;
  localparam int RX_COIN = 1;
  localparam int RX_SLOW = 2;

  // One output word, field by field.
  typedef struct packed {
    logic              kind;
    logic              key;
    logic              show;
    logic              exper;
    logic              lf;
    logic [2:0]        sts;
    logic [1:0]        corr;
    logic [3:0]        idx;
    logic [POS_W-1:0]  off;
    logic [POS_W-1:0]  len;
    logic              last;
  } desc_word_t;

  // One directed row: a byte, and for rows with chk set a header word typed in by
  // hand (flags are key, show, experimental, loop filter off).
  typedef struct packed {
    logic [7:0] b;
    logic       eof;
    logic       chk;
    status_t    sts;
    logic [3:0] flags;
  } stim_row_t;

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_wdata;
  logic                 in_valid;
  logic                 in_ready;
  logic [7:0]           in_data_byte;
  logic                 in_end_of_frame;
  logic                 out_valid;
  logic                 out_ready;
  logic                 out_item_kind;
  logic                 out_is_key_frame;
  logic                 out_show_flag;
  logic                 out_experimental_flag;
  logic                 out_loop_filter_off;
  logic [2:0]           out_status;
  logic [1:0]           out_corruption;
  logic [3:0]           out_part_index;
  logic [POS_W-1:0]     out_part_offset;
  logic [POS_W-1:0]     out_part_length;
  logic                 out_last_result;

  vp8_frame_header_parser dut (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .cfg_we                (cfg_we),
    .cfg_index             (cfg_index),
    .cfg_wdata             (cfg_wdata),
    .in_valid              (in_valid),
    .in_ready              (in_ready),
    .in_data_byte          (in_data_byte),
    .in_end_of_frame       (in_end_of_frame),
    .out_valid             (out_valid),
    .out_ready             (out_ready),
    .out_item_kind         (out_item_kind),
    .out_is_key_frame      (out_is_key_frame),
    .out_show_flag         (out_show_flag),
    .out_experimental_flag (out_experimental_flag),
    .out_loop_filter_off   (out_loop_filter_off),
    .out_status            (out_status),
    .out_corruption        (out_corruption),
    .out_part_index        (out_part_index),
    .out_part_offset       (out_part_offset),
    .out_part_length       (out_part_length),
    .out_last_result       (out_last_result)
  );

  // Decoder copy of the register file.
  logic [CFG_W-1:0] want_w;
  logic [CFG_W-1:0] want_h;
  logic             allow_partial;
  logic [3:0]       pcount_reg;

  // Decoder copy of the frame state.
  int unsigned      frame_pos;
  logic [7:0]       hdr_bytes [HEADER_BYTES];
  logic [POS_W-1:0] len_table [MAX_PARTS-1];

  desc_word_t pred_words [MAX_PARTS+1];
  desc_word_t expected_words [$];
  logic [7:0] frame_bytes [$];

  // Hand-typed override for the directed rows, sampled at acceptance.
  logic       row_typed;
  desc_word_t row_word;

  int  err_count;
  int  burst_left;
  bit  hold_req;

  // Reset at the start: error codes typed in, the good frames left to the decoder.
  stim_row_t directed_rows [NUM_DIRECTED] = '{
    // version 7 on a one-byte frame
    '{8'h0E, 1'b1, 1'b1, STS_BAD_VERSION, 4'b1000},
    // one-byte key frame, tag incomplete
    '{8'h00, 1'b1, 1'b1, STS_TRUNCATED, 4'b1000},
    // inter frame, first partition length all ones
    '{8'hF1, 1'b0, 1'b0, STS_OK, 4'b0000},
    '{8'hFF, 1'b0, 1'b0, STS_OK, 4'b0000},
    '{8'hFF, 1'b1, 1'b1, STS_BAD_LENGTH, 4'b0100},
    // version 6 inter frame, shown, two-byte first partition
    '{8'h5D, 1'b0, 1'b0, STS_OK, 4'b0000},
    '{8'h00, 1'b0, 1'b0, STS_OK, 4'b0000},
    '{8'h00, 1'b0, 1'b0, STS_OK, 4'b0000},
    '{8'hA5, 1'b0, 1'b0, STS_OK, 4'b0000},
    '{8'h5A, 1'b0, 1'b0, STS_OK, 4'b0000},
    '{8'h00, 1'b1, 1'b0, STS_OK, 4'b0000},
    // version 4 inter frame, empty first partition
    '{8'h19, 1'b0, 1'b0, STS_OK, 4'b0000},
    '{8'h00, 1'b0, 1'b0, STS_OK, 4'b0000},
    '{8'h00, 1'b0, 1'b0, STS_OK, 4'b0000},
    '{8'hFF, 1'b1, 1'b0, STS_OK, 4'b0000},
    // smallest good key frame at zero width and height
    '{8'h00, 1'b0, 1'b0, STS_OK, 4'b0000},
    '{8'h00, 1'b0, 1'b0, STS_OK, 4'b0000},
    '{8'h00, 1'b0, 1'b0, STS_OK, 4'b0000},
    '{8'h9D, 1'b0, 1'b0, STS_OK, 4'b0000},
    '{8'h01, 1'b0, 1'b0, STS_OK, 4'b0000},
    '{8'h2A, 1'b0, 1'b0, STS_OK, 4'b0000},
    '{8'h00, 1'b0, 1'b0, STS_OK, 4'b0000},
    '{8'h00, 1'b0, 1'b0, STS_OK, 4'b0000},
    '{8'h00, 1'b0, 1'b0, STS_OK, 4'b0000},
    '{8'h00, 1'b0, 1'b0, STS_OK, 4'b0000},
    '{8'h80, 1'b1, 1'b0, STS_OK, 4'b0000}
  };

  function automatic desc_word_t make_word(input kind_t kind, input logic key, show, exper,
                                           lf, input status_t sts, input corr_t corr,
                                           input int unsigned idx, off, len,
                                           input logic last);
    desc_word_t w;
    w.kind  = kind;
    w.key   = key;
    w.show  = show;
    w.exper = exper;
    w.lf    = lf;
    w.sts   = sts;
    w.corr  = corr;
    w.idx   = 4'(idx);
    w.off   = POS_W'(off);
    w.len   = POS_W'(len);
    w.last  = last;
    return w;
  endfunction

  function automatic string word_text(input desc_word_t w);
    return $sformatf({"kind=%0d key=%0d show=%0d exp=%0d lf=%0d status=%0d corr=%0d",
                      " idx=%0d off=%0d len=%0d last=%0d"}, w.kind, w.key, w.show,
                     w.exper, w.lf, w.sts, w.corr, w.idx, w.off, w.len, w.last);
  endfunction

  // Clamp the partition count register into 1..MAX_PARTS.
  function automatic int unsigned parts_in_use();
    if (pcount_reg == 0) return 1;
    if (pcount_reg > MAX_PARTS) return MAX_PARTS;
    return pcount_reg;
  endfunction

  // Frame decoder: take one byte, update position, header and length table, and at
  // the final byte fill pred_words. Return the number of words the byte causes.
  function automatic int parse_byte(input logic [7:0] b, input logic eof);
    int unsigned p, sz, q, tag_off, tag_len, fpo, fpl, r, need, pos, rem, l, w, h, n;
    int unsigned cnt, i;
    int unsigned d_off [MAX_PARTS];
    int unsigned d_len [MAX_PARTS];
    logic        key, show, exper, lf, trunc;
    logic [2:0]  ver;
    status_t     sts;
    corr_t       corr;
    p = frame_pos;
    fpo = 0;
    fpl = 0;
    cnt = 0;
    exper = 1'b0;
    lf = 1'b0;
    trunc = 1'b0;
    sts = STS_OK;
    corr = CORR_NONE;
    if (p < HEADER_BYTES) hdr_bytes[p] = b;
    tag_off = hdr_bytes[0][0] ? TAG_BYTES : HEADER_BYTES;
    tag_len = {hdr_bytes[2], hdr_bytes[1], hdr_bytes[0][7:5]};
    // Capture the DCT length table that trails the first partition.
    if (p >= TAG_BYTES && p >= tag_off + tag_len &&
        p - (tag_off + tag_len) < 3 * (MAX_PARTS - 1)) begin
      q = p - (tag_off + tag_len);
      len_table[q / 3][8 * (q % 3) +: 8] = b;
    end
    if (!eof) begin
      if (p < POS_MAX) frame_pos = p + 1;
      return 0;
    end
    sz = (p < POS_MAX) ? p + 1 : POS_MAX;
    frame_pos = 0;

    key  = ~hdr_bytes[0][0];
    show = hdr_bytes[0][4];
    ver  = hdr_bytes[0][3:1];
    if (ver != VER_BASE && ver != VER_EXPERIMENTAL && ver != VER_NO_LOOP_FILTER) begin
      sts = STS_BAD_VERSION;
    end else begin
      exper = (ver != VER_BASE);
      lf = (ver == VER_NO_LOOP_FILTER);
      if (sz < TAG_BYTES) begin
        trunc = 1'b1;
      end else begin
        if (sz <= tag_off + tag_len) begin
          if (!allow_partial) sts = STS_BAD_LENGTH;
          else if (sz < tag_off) trunc = 1'b1;
          else begin
            corr = CORR_FIRST;
            fpo = tag_off;
            fpl = sz - tag_off;
          end
        end else begin
          fpo = tag_off;
          fpl = tag_len;
        end
        if (sts == STS_OK && !trunc && key) begin
          if (sz < START_END) trunc = 1'b1;
          else if (hdr_bytes[3] != START_B0 || hdr_bytes[4] != START_B1 ||
                   hdr_bytes[5] != START_B2) sts = STS_NO_START;
          else if (sz < HEADER_BYTES) trunc = 1'b1;
          else begin
            w = {hdr_bytes[7][5:0], hdr_bytes[6]};
            h = {hdr_bytes[9][5:0], hdr_bytes[8]};
            if (w != want_w || h != want_h || hdr_bytes[7][7:6] != 2'b00 ||
                hdr_bytes[9][7:6] != 2'b00) sts = STS_SIZE_SCALE;
          end
        end
      end
      if (sts == STS_OK && trunc) begin
        if (!allow_partial) sts = STS_TRUNCATED;
        else begin
          corr = CORR_FRAME;
          key = 1'b0;
          exper = 1'b0;
          lf = 1'b0;
          fpo = 0;
          fpl = 0;
        end
      end
    end
    if (sts != STS_OK) begin
      pred_words[0] = make_word(KIND_HEADER, key, show, exper, lf, sts, corr, 0, 0, 0, 1'b1);
      return 1;
    end

    n = parts_in_use();
    if (corr != CORR_NONE) begin
      // No table in a corrupted frame: one empty partition at the end, or overrun.
      if (n == 1) begin
        d_off[0] = sz;
        d_len[0] = 0;
        cnt = 1;
      end else begin
        sts = STS_OVERRUN;
      end
    end else begin
      r = tag_off + tag_len;
      need = 3 * (n - 1);
      if (sz - r < need) begin
        sts = STS_OVERRUN;
      end else begin
        pos = r + need;
        rem = sz - pos;
        for (i = 0; i + 1 < n; i++) begin
          l = len_table[i];
          if (l > rem) begin
            sts = STS_OVERRUN;
            break;
          end
          d_off[i] = pos;
          d_len[i] = l;
          pos += l;
          rem -= l;
        end
        if (sts == STS_OK) begin
          d_off[n-1] = pos;
          d_len[n-1] = rem;
          cnt = n;
        end
      end
    end
    if (sts != STS_OK) begin
      pred_words[0] = make_word(KIND_HEADER, key, show, exper, lf, sts, corr, 0, fpo, fpl,
                                1'b1);
      return 1;
    end
    pred_words[0] = make_word(KIND_HEADER, key, show, exper, lf, STS_OK, corr, 0, fpo, fpl,
                              cnt == 0);
    for (i = 0; i < cnt; i++) begin
      pred_words[i+1] = make_word(KIND_PART, key, show, exper, lf, STS_OK, corr, i + 1,
                                  d_off[i], d_len[i], i + 1 == cnt);
    end
    return cnt + 1;
  endfunction

  // Clock: period 10.
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Predict on every accepted byte; directed rows with a typed header replace it.
  always @(posedge clk) begin : take_byte
    int cnt;
    if (rst_n && in_valid && in_ready) begin
      cnt = parse_byte(in_data_byte, in_end_of_frame);
      if (row_typed && cnt > 0) begin
        expected_words.push_back(row_word);
      end else begin
        for (int i = 0; i < cnt; i++) expected_words.push_back(pred_words[i]);
      end
    end
  end

  task automatic note_error(input string msg);
    err_count++;
    if (err_count <= MAX_REPORTS) $display("%s", msg);
  endtask

  // Check every accepted output word against the oldest expectation.
  always @(posedge clk) begin : check_word
    desc_word_t seen, want;
    string      diff;
    if (rst_n && out_valid && out_ready) begin
      seen = '{out_item_kind, out_is_key_frame, out_show_flag, out_experimental_flag,
               out_loop_filter_off, out_status, out_corruption, out_part_index,
               out_part_offset, out_part_length, out_last_result};
      if (expected_words.size() == 0) begin
        note_error($sformatf("word with nothing expected: %s", word_text(seen)));
      end else begin
        want = expected_words.pop_front();
        diff = "";
        if (seen.kind  !== want.kind)  diff = {diff, " item_kind"};
        if (seen.key   !== want.key)   diff = {diff, " is_key_frame"};
        if (seen.show  !== want.show)  diff = {diff, " show_flag"};
        if (seen.exper !== want.exper) diff = {diff, " experimental_flag"};
        if (seen.lf    !== want.lf)    diff = {diff, " loop_filter_off"};
        if (seen.sts   !== want.sts)   diff = {diff, " status"};
        if (seen.corr  !== want.corr)  diff = {diff, " corruption"};
        if (seen.idx   !== want.idx)   diff = {diff, " part_index"};
        if (seen.off   !== want.off)   diff = {diff, " part_offset"};
        if (seen.len   !== want.len)   diff = {diff, " part_length"};
        if (seen.last  !== want.last)  diff = {diff, " last_result"};
        if (diff != "") begin
          note_error($sformatf("mismatch in%s\n  expected %s\n  actual   %s", diff,
                               word_text(want), word_text(seen)));
        end
      end
    end
  end

  // Receiver: switch among stall patterns; on request hold off for a long stretch so
  // the block backs up into its input.
  initial begin : receiver
    int pat_mode, pat_left;
    out_ready = 1'b0;
    pat_mode = RX_FREE;
    pat_left = 0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_ready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_req = 1'b0;
      end
      if (pat_left == 0) begin
        pat_mode = $urandom_range(RX_FREE, RX_SLOW);
        pat_left = $urandom_range(8, 64);
      end
      pat_left--;
      case (pat_mode)
        RX_FREE: out_ready = 1'b1;
        RX_COIN: out_ready = 1'($urandom_range(0, 1));
        default: out_ready = ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  // Watchdog: end the run when nothing moves on either channel for too long.
  initial begin : watchdog
    int idle;
    idle = 0;
    while (idle < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) idle = 0;
      else idle++;
    end
    $display("DONE: errors detected");
    $finish;
  end

  // Offer one word from a falling edge; hold it until accepted, then drop valid.
  // Bursts of random length are separated by random gaps, some of them zero.
  task automatic send_word(input logic [7:0] b, input logic eof);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    burst_left--;
    in_valid = 1'b1;
    in_data_byte = b;
    in_end_of_frame = eof;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [CFG_W-1:0] val);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_wdata = val;
    @(negedge clk);
    cfg_we = 1'b0;
    case (idx)
      REG_WIDTH:   want_w = val;
      REG_HEIGHT:  want_h = val;
      REG_PARTIAL: allow_partial = val[0];
      default:     pcount_reg = val[3:0];
    endcase
  endtask

  task automatic program_regs(input logic [CFG_W-1:0] w, h, input logic partial,
                              input logic [3:0] pcount);
    write_reg(REG_WIDTH, w);
    write_reg(REG_HEIGHT, h);
    write_reg(REG_PARTIAL, CFG_W'(partial));
    write_reg(REG_PCOUNT, CFG_W'(pcount));
  endtask

  // Wait until every expected word has come, then let the block settle.
  task automatic drain(input int cycles);
    while (expected_words.size() != 0) @(negedge clk);
    repeat (cycles) @(negedge clk);
  endtask

  // Build one frame into frame_bytes: mostly well-formed frames with random content
  // for the current settings, some broken ones (bad start code, size, scale,
  // version, huge lengths, cut short), and some plain noise.
  task automatic build_frame();
    int unsigned flen, l, keep, data_len;
    logic        key, show;
    logic [2:0]  ver;
    logic [13:0] w, h;
    logic [1:0]  sw, sh;
    frame_bytes.delete();
    if ($urandom_range(0, 9) >= 8) begin
      repeat ($urandom_range(1, 14)) frame_bytes.push_back(8'($urandom));
      return;
    end
    key = 1'($urandom_range(0, 1));
    show = 1'($urandom_range(0, 1));
    case ($urandom_range(0, 9))
      0:       ver = 3'($urandom);
      1, 2, 3: ver = VER_EXPERIMENTAL;
      4, 5, 6: ver = VER_NO_LOOP_FILTER;
      default: ver = VER_BASE;
    endcase
    flen = ($urandom_range(0, 19) == 0) ? $urandom_range(0, 19'h7FFFF) : $urandom_range(0, 4);
    frame_bytes.push_back({flen[2:0], show, ver, ~key});
    frame_bytes.push_back(flen[10:3]);
    frame_bytes.push_back(flen[18:11]);
    if (key) begin
      frame_bytes.push_back(START_B0);
      frame_bytes.push_back(START_B1);
      frame_bytes.push_back(START_B2);
      if ($urandom_range(0, 11) == 0)
        frame_bytes[3 + $urandom_range(0, 2)] ^= 8'(1 << $urandom_range(0, 7));
      w = ($urandom_range(0, 9) == 0) ? 14'($urandom) : want_w;
      h = ($urandom_range(0, 9) == 0) ? 14'($urandom) : want_h;
      sw = ($urandom_range(0, 11) == 0) ? 2'($urandom) : 2'b00;
      sh = ($urandom_range(0, 11) == 0) ? 2'($urandom) : 2'b00;
      frame_bytes.push_back(w[7:0]);
      frame_bytes.push_back({sw, w[13:8]});
      frame_bytes.push_back(h[7:0]);
      frame_bytes.push_back({sh, h[13:8]});
    end
    repeat ((flen > 6) ? 6 : flen) frame_bytes.push_back(8'($urandom));
    // Length table; a rare huge entry runs past the frame end.
    data_len = 0;
    for (int i = 1; i < parts_in_use(); i++) begin
      l = ($urandom_range(0, 14) == 0) ? $urandom_range(0, 24'hFFFFFF) : $urandom_range(0, 3);
      frame_bytes.push_back(l[7:0]);
      frame_bytes.push_back(l[15:8]);
      frame_bytes.push_back(l[23:16]);
      if (l <= 3) data_len += l;
    end
    data_len += $urandom_range(0, 3);
    repeat (data_len) frame_bytes.push_back(8'($urandom));
    if ($urandom_range(0, 7) == 0) begin
      keep = $urandom_range(1, frame_bytes.size());
      while (frame_bytes.size() > keep) void'(frame_bytes.pop_back());
    end
  endtask

  // Stimulus: reset, directed rows, then six phases of random frames, each under a
  // new register setting written only while the block is idle.
  initial begin : sender
    int phase, sent;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = REG_WIDTH;
    cfg_wdata = '0;
    in_valid = 1'b0;
    in_data_byte = 8'h00;
    in_end_of_frame = 1'b0;
    row_typed = 1'b0;
    row_word = '0;
    err_count = 0;
    burst_left = 0;
    hold_req = 1'b0;
    want_w = '0;
    want_h = '0;
    allow_partial = 1'b0;
    pcount_reg = 4'd1;
    frame_pos = 0;
    foreach (hdr_bytes[i]) hdr_bytes[i] = 8'h00;
    foreach (len_table[i]) len_table[i] = '0;
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed rows at reset settings; typed rows carry their header word.
    foreach (directed_rows[k]) begin
      row_typed = directed_rows[k].chk;
      row_word = make_word(KIND_HEADER, directed_rows[k].flags[3], directed_rows[k].flags[2],
                           directed_rows[k].flags[1], directed_rows[k].flags[0],
                           directed_rows[k].sts, CORR_NONE, 0, 0, 0, 1'b1);
      send_word(directed_rows[k].b, directed_rows[k].eof);
    end
    row_typed = 1'b0;

    for (phase = 0; phase < NUM_PHASES; phase++) begin
      if (phase > 0) begin
        // Pause the sender until every word is out, then reprogram.
        drain(SETTLE_CYCLES);
        case (phase)
          1: program_regs('1, '1, 1'b1, 4'd8);
          2: program_regs('0, '0, 1'b0, 4'd15);
          3: program_regs(14'($urandom), 14'($urandom), 1'b1, 4'd0);
          4: program_regs(14'($urandom), 14'($urandom), 1'b0, 4'($urandom_range(2, 7)));
          default: program_regs(14'($urandom), 14'($urandom), 1'b1,
                                4'($urandom_range(1, 8)));
        endcase
        // Stall the receiver for a long stretch while frames keep coming.
        if (phase == 2) hold_req = 1'b1;
      end
      sent = 0;
      while (sent < PHASE_WORDS) begin
        build_frame();
        foreach (frame_bytes[i]) send_word(frame_bytes[i], i == frame_bytes.size() - 1);
        sent += frame_bytes.size();
      end
    end

    drain(SETTLE_CYCLES);
    if (err_count == 0 && expected_words.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
src/vfh_pkg.sv
src/vfh_ctrl.sv
src/vfh_dp.sv
src/vp8_frame_header_parser.sv
tb/tb_top.sv
